// ===== rtl/core/xor_checked_sentence_parser_unit_macros.svh =====
// Assertion helpers shared by the sentence parser RTL.
// Each macro is empty when SYNTHESIS is defined.
`ifndef XOR_CHECKED_SENTENCE_PARSER_UNIT_MACROS_SVH
`define XOR_CHECKED_SENTENCE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define XCSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define XCSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XCSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define XCSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/xcsp_pkg.sv =====
package xcsp_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int CODE_W = 3;

    // Header layout and command table.
    localparam int HDR_LEN  = 5;
    localparam int HDR_W    = HDR_LEN * BYTE_W;
    localparam int NUM_CMDS = 5;

    // Special characters.
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

    // Command codes.
    localparam logic [CODE_W-1:0] CMD_PSIGN   = 3'd0;
    localparam logic [CODE_W-1:0] CMD_PINFO   = 3'd1;
    localparam logic [CODE_W-1:0] CMD_PFLSH   = 3'd2;
    localparam logic [CODE_W-1:0] CMD_PBLFL   = 3'd3;
    localparam logic [CODE_W-1:0] CMD_PEEPR   = 3'd4;
    localparam logic [CODE_W-1:0] CMD_UNKNOWN = 3'd5;

    // Header names, first character in the top byte.
    localparam logic [HDR_W-1:0] CMD_NAMES [NUM_CMDS] =
        '{"PSIGN", "PINFO", "PFLSH", "PBLFL", "PEEPR"};
    localparam logic [CODE_W-1:0] CMD_CODES [NUM_CMDS] =
        '{CMD_PSIGN, CMD_PINFO, CMD_PFLSH, CMD_PBLFL, CMD_PEEPR};

    // One sentence result.
    typedef struct packed {
        logic              checksum_ok;
        logic [CODE_W-1:0] command_code;
        logic [LEN_W-1:0]  body_length;
        logic              too_long;
    } xcsp_result_t;

    // Upper-case ASCII hex digit of a nibble.
    function automatic logic [BYTE_W-1:0] hex_upper(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide_nib;
        wide_nib = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            hex_upper = 8'h30 + wide_nib;
        end
        else
        begin
            hex_upper = 8'h37 + wide_nib;
        end
    endfunction

endpackage

// ===== rtl/core/xcsp_in_reg.sv =====
module xcsp_in_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  logic [xcsp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                         advance,
    output logic                         stage_valid,
    output logic [xcsp_pkg::BYTE_W-1:0]  stage_byte
);
    import xcsp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              load;

    // The stage takes a new transaction when it is empty or its byte moves on.
    assign load       = !valid_reg || advance;
    assign byte_stall = !load;
    assign valid_next = load ? byte_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte holder, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load && byte_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

// ===== rtl/core/xcsp_parser.sv =====
module xcsp_parser #(
    parameter int MAX_BODY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [xcsp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         emit,
    output xcsp_pkg::xcsp_result_t       result
);
    import xcsp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BODY + 1);
    localparam int WIDE_W = CNT_W + LEN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BODY);
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HDR_LEN);

    logic              in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0]  body_count_reg, body_count_next;
    logic [BYTE_W-1:0] running_xor_reg, running_xor_next;
    logic              star_seen_reg, star_seen_next;
    logic [1:0]        digits_reg, digits_next;
    logic [BYTE_W-1:0] high_char_reg, high_char_next;
    logic [BYTE_W-1:0] low_char_reg, low_char_next;
    logic              overflow_reg, overflow_next;
    logic [BYTE_W-1:0] header_reg [HDR_LEN];
    logic              hdr_write;
    logic [HDR_W-1:0]  header_word;
    logic [CODE_W-1:0] cmd_code;
    logic [WIDE_W-1:0] count_wide;

    // Sentence state update for one byte.
    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        body_count_next  = body_count_reg;
        running_xor_next = running_xor_reg;
        star_seen_next   = star_seen_reg;
        digits_next      = digits_reg;
        high_char_next   = high_char_reg;
        low_char_next    = low_char_reg;
        overflow_next    = overflow_reg;
        hdr_write        = 1'b0;
        if (rx_byte == CH_DOLLAR)
        begin
            in_sentence_next = 1'b1;
            body_count_next  = '0;
            running_xor_next = '0;
            star_seen_next   = 1'b0;
            digits_next      = 2'd0;
            high_char_next   = '0;
            low_char_next    = '0;
            overflow_next    = 1'b0;
        end
        else if (in_sentence_reg)
        begin
            if (rx_byte == CH_NL)
            begin
                in_sentence_next = 1'b0;
            end
            else if (!star_seen_reg)
            begin
                if (rx_byte == CH_STAR)
                begin
                    star_seen_next = 1'b1;
                end
                else
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    hdr_write        = body_count_reg < HDR_CNT;
                    if (body_count_reg < MAX_CNT)
                    begin
                        body_count_next = body_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            else if (digits_reg == 2'd0)
            begin
                high_char_next = rx_byte;
                digits_next    = 2'd1;
            end
            else if (digits_reg == 2'd1)
            begin
                low_char_next = rx_byte;
                digits_next   = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            body_count_reg  <= '0;
            running_xor_reg <= '0;
            star_seen_reg   <= 1'b0;
            digits_reg      <= 2'd0;
            high_char_reg   <= '0;
            low_char_reg    <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (step)
        begin
            in_sentence_reg <= in_sentence_next;
            body_count_reg  <= body_count_next;
            running_xor_reg <= running_xor_next;
            star_seen_reg   <= star_seen_next;
            digits_reg      <= digits_next;
            high_char_reg   <= high_char_next;
            low_char_reg    <= low_char_next;
            overflow_reg    <= overflow_next;
        end
    end

    // Header bytes are only read once five of them have been written.
    always_ff @(posedge clk)
    begin
        if (step && hdr_write)
        begin
            header_reg[body_count_reg[2:0]] <= rx_byte;
        end
    end

    // Command lookup over the five names.
    assign header_word = {header_reg[0], header_reg[1], header_reg[2],
                          header_reg[3], header_reg[4]};

    always_comb
    begin
        cmd_code = CMD_UNKNOWN;
        if (body_count_reg >= HDR_CNT)
        begin
            for (int i = NUM_CMDS - 1; i >= 0; i--)
            begin
                if (header_word == CMD_NAMES[i])
                begin
                    cmd_code = CMD_CODES[i];
                end
            end
        end
    end

    // A newline inside a sentence that saw a star closes it with a result.
    assign emit = in_sentence_reg && star_seen_reg && (rx_byte == CH_NL);

    assign count_wide = WIDE_W'(body_count_reg);

    assign result.checksum_ok  = (digits_reg == 2'd2) &&
                                 (high_char_reg == hex_upper(running_xor_reg[7:4])) &&
                                 (low_char_reg == hex_upper(running_xor_reg[3:0]));
    assign result.command_code = cmd_code;
    assign result.body_length  = count_wide[LEN_W-1:0];
    assign result.too_long     = overflow_reg;

endmodule

// ===== rtl/core/xcsp_out_reg.sv =====
module xcsp_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  xcsp_pkg::xcsp_result_t  push_data,
    input  logic                    result_stall,
    output logic                    result_valid,
    output xcsp_pkg::xcsp_result_t  result_data,
    output logic                    free
);
    import xcsp_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    xcsp_result_t data_reg;

    // The register can be loaded when empty or when its transaction leaves now.
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

// ===== rtl/core/xor_checked_sentence_parser_unit.sv =====
// Channel   Direction  Handshake                  Payload
// byte      in         byte_valid / byte_stall    rx_byte
// result    out        result_valid / result_stall checksum_ok, command_code,
//                                                  body_length, too_long
//
// One byte is taken every cycle while byte_stall is low; a sentence's
// result is computed from the newline byte held in the input register and
// is loaded into the result register when that byte moves on.
// Reset is asynchronous and active low; it clears the sentence state but not the stored header bytes.
// A newline byte that closes a sentence with a result waits in the input
// register while the result register is full and stalled; other bytes move on regardless.
module xor_checked_sentence_parser_unit #(
    parameter int MAX_BODY = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [xcsp_pkg::BYTE_W-1:0]       rx_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              checksum_ok,
    output logic [xcsp_pkg::CODE_W-1:0]       command_code,
    output logic [xcsp_pkg::LEN_W-1:0]        body_length,
    output logic                              too_long
);
    import xcsp_pkg::*;

`include "xor_checked_sentence_parser_unit_macros.svh"

    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    logic              advance;
    logic              emit;
    logic              push;
    logic              out_free;
    xcsp_result_t      parse_result;
    xcsp_result_t      out_result;

    // Input register.
    xcsp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    // A byte moves on unless it closes a sentence with a result and the result slot is busy.
    assign advance = stage_valid && (out_free || !emit);
    assign push    = advance && emit;

    xcsp_parser #(
        .MAX_BODY (MAX_BODY)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (stage_byte),
        .emit    (emit),
        .result  (parse_result)
    );

    // Result register.
    xcsp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (parse_result),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (out_result),
        .free         (out_free)
    );

    assign checksum_ok  = out_result.checksum_ok;
    assign command_code = out_result.command_code;
    assign body_length  = out_result.body_length;
    assign too_long     = out_result.too_long;

    // Checks on the pipeline control.
    `XCSP_ASSERT(a_push_needs_room, clk, rst_n, !push || out_free, "result pushed into a busy register")
    `XCSP_ASSERT_NEXT(a_push_shows_result, clk, rst_n, push, result_valid, "pushed result not visible")
    `XCSP_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, stage_valid && !advance, stage_valid && $stable(stage_byte), "held byte lost or changed")

endmodule

// ===== tb/xor_checked_sentence_parser_unit_test.sv =====
`timescale 1ns / 1ps

module xor_checked_sentence_parser_unit_test;
    import xcsp_pkg::*;

    localparam int BODY_LIMIT   = 1024;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_ITEMS  = 30;
    localparam int TIMEOUT_NS   = 1000000;
    localparam int MAX_PRINTED  = 40;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    // How a sentence is closed after its body.
    typedef enum int {
        SUM_GOOD,
        SUM_BAD,
        SUM_LOWER,
        SUM_ONE_DIGIT,
        SUM_NO_DIGITS,
        SUM_NO_STAR,
        SUM_DOUBLE_STAR
    } sum_kind_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic                byte_stall;
    logic [BYTE_W-1:0]   rx_byte      = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                checksum_ok;
    logic [CODE_W-1:0]   command_code;
    logic [LEN_W-1:0]    body_length;
    logic                too_long;

    int idle_pct       = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;

    // Mirror of the parser state, updated on every accepted byte.
    logic              in_frame       = 1'b0;
    int                frame_len      = 0;
    logic [BYTE_W-1:0] frame_xor      = '0;
    logic              star_hit       = 1'b0;
    int                digit_count    = 0;
    logic [BYTE_W-1:0] hi_digit       = '0;
    logic [BYTE_W-1:0] lo_digit       = '0;
    logic              frame_overflow = 1'b0;
    logic [BYTE_W-1:0] header [HDR_LEN];

    // Sentence results still owed by the block, oldest first.
    xcsp_result_t sentence_q [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    xor_checked_sentence_parser_unit #(
        .MAX_BODY(BODY_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .rx_byte(rx_byte),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .checksum_ok(checksum_ok),
        .command_code(command_code),
        .body_length(body_length),
        .too_long(too_long)
    );

    // ASCII upper-case hex digit of one nibble.
    function automatic logic [BYTE_W-1:0] nibble_ascii(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            return 8'h30 + wide;
        end
        return 8'h41 + wide - 8'd10;
    endfunction

    // Command named by the first five body bytes of the current sentence.
    function automatic logic [CODE_W-1:0] header_code();
        logic [HDR_W-1:0]  packed_hdr;
        logic [CODE_W-1:0] code;
        code = CMD_UNKNOWN;
        packed_hdr = {header[0], header[1], header[2], header[3], header[4]};
        if (frame_len >= HDR_LEN)
        begin
            for (int c = 0; c < NUM_CMDS; c++)
            begin
                if (packed_hdr == CMD_NAMES[c])
                begin
                    code = CMD_CODES[c];
                end
            end
        end
        return code;
    endfunction

    // Advance the mirrored parser by one byte and queue any sentence result.
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        xcsp_result_t res;
        if (b == CH_DOLLAR)
        begin
            in_frame       = 1'b1;
            frame_len      = 0;
            frame_xor      = '0;
            star_hit       = 1'b0;
            digit_count    = 0;
            hi_digit       = '0;
            lo_digit       = '0;
            frame_overflow = 1'b0;
        end
        else if (in_frame)
        begin
            if (b == CH_NL)
            begin
                in_frame = 1'b0;
                if (star_hit)
                begin
                    res.checksum_ok  = (digit_count == 2) &&
                                       (hi_digit == nibble_ascii(frame_xor[7:4])) &&
                                       (lo_digit == nibble_ascii(frame_xor[3:0]));
                    res.command_code = header_code();
                    res.body_length  = frame_len[LEN_W-1:0];
                    res.too_long     = frame_overflow;
                    sentence_q.push_back(res);
                end
            end
            else if (!star_hit)
            begin
                if (b == CH_STAR)
                begin
                    star_hit = 1'b1;
                end
                else
                begin
                    frame_xor ^= b;
                    if (frame_len < HDR_LEN)
                    begin
                        header[frame_len] = b;
                    end
                    if (frame_len < BODY_LIMIT)
                    begin
                        frame_len++;
                    end
                    else
                    begin
                        frame_overflow = 1'b1;
                    end
                end
            end
            else if (digit_count == 0)
            begin
                hi_digit    = b;
                digit_count = 1;
            end
            else if (digit_count == 1)
            begin
                lo_digit    = b;
                digit_count = 2;
            end
        end
    endtask

    // One byte transaction, with an optional idle burst in front of it.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        bit taken;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        do
        begin
            @(negedge clk);
            taken = !byte_stall;
            @(posedge clk);
        end
        while (!taken);
        predict_byte(b);
        bytes_sent++;
    endtask

    // A random body byte that is none of the framing characters.
    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            b = BYTE_W'($urandom_range(255, 0));
        end
        while (b == CH_DOLLAR || b == CH_STAR || b == CH_NL);
        return b;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        foreach (s[i])
        begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic byte_q_t command_bytes(input int c);
        byte_q_t q;
        for (int k = 0; k < HDR_LEN; k++)
        begin
            q.push_back(CMD_NAMES[c][HDR_W-1-8*k -: 8]);
        end
        return q;
    endfunction

    // Send a whole sentence: dollar, body, a checksum tail of the given kind,
    // some trailing bytes and the newline.
    task automatic send_sentence(input byte_q_t body, input sum_kind_t kind,
                                 input int trailing);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        sum = '0;
        foreach (body[i])
        begin
            sum ^= body[i];
        end
        hi = nibble_ascii(sum[7:4]);
        lo = nibble_ascii(sum[3:0]);
        send_byte(CH_DOLLAR);
        foreach (body[i])
        begin
            send_byte(body[i]);
        end
        if (kind != SUM_NO_STAR)
        begin
            send_byte(CH_STAR);
        end
        case (kind)
            SUM_GOOD:
            begin
                send_byte(hi);
                send_byte(lo);
            end
            SUM_BAD:
            begin
                send_byte(hi);
                send_byte(lo ^ 8'h01);
            end
            SUM_LOWER:
            begin
                send_byte(hi | 8'h20);
                send_byte(lo | 8'h20);
            end
            SUM_ONE_DIGIT:
            begin
                send_byte(hi);
            end
            SUM_DOUBLE_STAR:
            begin
                send_byte(CH_STAR);
                send_byte(lo);
            end
            default:
            begin
            end
        endcase
        repeat (trailing) send_byte(body_byte());
        send_byte(CH_NL);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        end
    endtask

    // Result stall in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(6, 0);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Check each result transaction against the oldest expected sentence.
    always @(negedge clk)
    begin
        xcsp_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (sentence_q.size() == 0)
            begin
                report_mismatch("result with none expected", int'(body_length), 0);
            end
            else
            begin
                want = sentence_q.pop_front();
                if (checksum_ok !== want.checksum_ok)
                begin
                    report_mismatch("checksum_ok", int'(checksum_ok),
                                    int'(want.checksum_ok));
                end
                if (command_code !== want.command_code)
                begin
                    report_mismatch("command_code", int'(command_code),
                                    int'(want.command_code));
                end
                if (body_length !== want.body_length)
                begin
                    report_mismatch("body_length", int'(body_length),
                                    int'(want.body_length));
                end
                if (too_long !== want.too_long)
                begin
                    report_mismatch("too_long", int'(too_long), int'(want.too_long));
                end
            end
        end
    end

    // Bytes outside any sentence, newline included, give nothing.
    task automatic test_out_of_frame();
        send_byte(CH_NL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_STAR);
        send_byte(8'h41);
    endtask

    // Every known command, an unknown one, a short header, a header with one extra byte and an empty body.
    task automatic test_command_headers();
        byte_q_t body;
        for (int c = 0; c < NUM_CMDS; c++)
        begin
            send_sentence(command_bytes(c), SUM_GOOD, 0);
        end
        send_sentence(text_bytes("PXXXX"), SUM_GOOD, 0);
        send_sentence(text_bytes("PSIG"), SUM_GOOD, 0);
        body = command_bytes(0);
        body.push_back(8'h58);
        send_sentence(body, SUM_GOOD, 0);
        body.delete();
        send_sentence(body, SUM_GOOD, 0);
    endtask

    // Checksum tails: wrong, lower case, short, missing digits, second star,
    // trailing bytes, and the byte extremes inside the body.
    task automatic test_checksum_forms();
        byte_q_t body;
        send_sentence(command_bytes(0), SUM_BAD, 0);
        send_sentence(text_bytes("J"), SUM_LOWER, 0);
        send_sentence(command_bytes(1), SUM_ONE_DIGIT, 0);
        send_sentence(command_bytes(2), SUM_NO_DIGITS, 0);
        send_sentence(command_bytes(3), SUM_DOUBLE_STAR, 0);
        send_sentence(command_bytes(4), SUM_GOOD, 3);
        body = command_bytes(0);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_sentence(body, SUM_GOOD, 0);
    endtask

    // Sentences dropped without a star, restarted mid-way, or empty.
    task automatic test_framing_cases();
        byte_q_t body;
        send_sentence(command_bytes(0), SUM_NO_STAR, 0);
        send_byte(CH_DOLLAR);
        body = command_bytes(4);
        foreach (body[i])
        begin
            send_byte(body[i]);
        end
        send_sentence(command_bytes(1), SUM_GOOD, 0);
        send_byte(CH_DOLLAR);
        send_byte(CH_NL);
    endtask

    // A body two bytes over the limit: the count saturates and the flag is set.
    task automatic test_overflow();
        byte_q_t body;
        body = command_bytes(2);
        while (body.size() < BODY_LIMIT + 2)
        begin
            body.push_back(body_byte());
        end
        send_sentence(body, SUM_GOOD, 0);
    endtask

    // Mostly well-formed sentences with random content, plus broken ones
    // and line noise; the last stretch runs without any idling.
    task automatic test_random_traffic();
        byte_q_t   body;
        sum_kind_t kind;
        int        start;
        int        pick;
        int        tail;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            if (bytes_sent - start > RANDOM_ITEMS - QUIET_ITEMS)
            begin
                idle_pct = 0;
            end
            else if ($urandom_range(15, 0) == 0)
            begin
                case ($urandom_range(2, 0))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end

            // Header: a real command, a corrupted one, or none at all.
            body.delete();
            pick = $urandom_range(9, 0);
            if (pick < 8)
            begin
                body = command_bytes($urandom_range(NUM_CMDS - 1, 0));
                if (pick >= 6)
                begin
                    body[$urandom_range(HDR_LEN - 1, 0)] = body_byte();
                end
            end
            repeat ($urandom_range(12, 0)) body.push_back(body_byte());

            pick = $urandom_range(19, 0);
            if (pick < 12)       kind = SUM_GOOD;
            else if (pick == 12) kind = SUM_BAD;
            else if (pick == 13) kind = SUM_LOWER;
            else if (pick == 14) kind = SUM_ONE_DIGIT;
            else if (pick == 15) kind = SUM_NO_DIGITS;
            else if (pick == 16) kind = SUM_NO_STAR;
            else                 kind = SUM_DOUBLE_STAR;

            if (pick == 18)
            begin
                // Raw noise between sentences.
                repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255, 0)));
            end
            else if (pick == 19)
            begin
                // Abandoned sentence that the next dollar restarts.
                send_byte(CH_DOLLAR);
                foreach (body[i])
                begin
                    send_byte(body[i]);
                end
            end
            else
            begin
                tail = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : 0;
                send_sentence(body, kind, tail);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 20;
        test_out_of_frame();
        test_command_headers();
        test_checksum_forms();
        test_framing_cases();
        idle_pct = 10;
        test_overflow();
        test_random_traffic();
        idle_pct = 0;
        byte_valid <= 1'b0;
        while (sentence_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("xor_checked_sentence_parser_unit_test OK");
        end
        else
        begin
            $display("xor_checked_sentence_parser_unit_test NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("xor_checked_sentence_parser_unit_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/xcsp_pkg.sv
rtl/core/xcsp_in_reg.sv
rtl/core/xcsp_parser.sv
rtl/core/xcsp_out_reg.sv
rtl/core/xor_checked_sentence_parser_unit.sv
tb/xor_checked_sentence_parser_unit_test.sv
